// ----- hw/rtl/cws_pkg.sv -----
`default_nettype none

package cws_pkg;

    // Field and register widths.
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int TC_W       = 3;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COEF_REGS  = 6;

    // Fraction bits of the gain, of the result and of the weights.
    localparam int GAIN_SHIFT = 15;
    localparam int OUT_FRAC   = 15;
    localparam int COEF_FRAC  = 12;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TERMS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF5 = 3'd7;

    // Values after reset.
    localparam logic signed [GAIN_W-1:0] GAIN_RST  = 16'sd32767;
    localparam logic [TC_W-1:0]          TC_RST    = 3'd2;
    localparam logic signed [COEF_W-1:0] COEF1_RST = 16'sd4096;

    // Forward control of one pipeline stage.
    typedef struct packed {
        logic vld;
        logic last;
    } t_beat;

endpackage

`default_nettype wire

// ----- hw/rtl/cws_front.sv -----
`default_nettype none

module cws_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 37
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire cws_pkg::t_beat                     i_beat,
    output logic                                    o_rdy,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  wire logic signed [cws_pkg::GAIN_W-1:0]  i_gain,
    input  wire logic signed [cws_pkg::COEF_W-1:0]  i_coef0,
    output cws_pkg::t_beat                          o_beat,
    input  wire logic                               i_rdy,
    output logic signed [SAMPLE_BITS:0]             o_x,
    output logic signed [ACC_W-1:0]                 o_acc
);
    import cws_pkg::*;

    localparam int F   = SAMPLE_BITS - 1;
    localparam int XW  = SAMPLE_BITS + 1;
    localparam int PW  = SAMPLE_BITS + GAIN_W;
    localparam int PAD = ACC_W - COEF_W - F;

    localparam logic signed [XW-1:0] ONE     = {2'b01, {F{1'b0}}};
    localparam logic signed [XW-1:0] NEG_ONE = {2'b11, {F{1'b0}}};

    t_beat                  r_p_beat;
    logic signed [PW-1:0]   r_p_prod;
    t_beat                  r_q_beat;
    logic signed [XW-1:0]   r_q_x;
    logic signed [ACC_W-1:0] r_q_acc;

    logic                   n_rdy1;
    logic                   n_rdy2;
    logic signed [PW-1:0]   n_prod;
    logic signed [XW-1:0]   n_sh;
    logic signed [XW-1:0]   n_x;
    logic signed [ACC_W-1:0] n_acc;

    assign n_rdy2 = !r_q_beat.vld || i_rdy;
    assign n_rdy1 = !r_p_beat.vld || n_rdy2;

    assign n_prod = i_sample * i_gain;

    // The product is Q2.(F+15); dropping 15 bits floors it to Q2.F.
    assign n_sh = $signed(r_p_prod[PW-1:GAIN_SHIFT]);
    assign n_x  = (n_sh > ONE) ? ONE : ((n_sh < NEG_ONE) ? NEG_ONE : n_sh);

    // Weight of T0 times the constant one.
    assign n_acc = {{PAD{i_coef0[COEF_W-1]}}, i_coef0, {F{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_beat <= '0;
            r_q_beat <= '0;
        end else begin
            if (n_rdy1) r_p_beat <= i_beat;
            if (n_rdy2) r_q_beat <= r_p_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy1 && i_beat.vld) begin
            r_p_prod <= n_prod;
        end
        if (n_rdy2 && r_p_beat.vld) begin
            r_q_x   <= n_x;
            r_q_acc <= n_acc;
        end
    end

    assign o_rdy  = n_rdy1;
    assign o_beat = r_q_beat;
    assign o_x    = r_q_x;
    assign o_acc  = r_q_acc;

endmodule

`default_nettype wire

// ----- hw/rtl/cws_cell.sv -----
`default_nettype none

module cws_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 37
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire cws_pkg::t_beat                     i_beat,
    output logic                                    o_rdy,
    input  wire logic signed [SAMPLE_BITS:0]        i_x,
    input  wire logic signed [SAMPLE_BITS:0]        i_cur,
    input  wire logic signed [SAMPLE_BITS:0]        i_prev,
    input  wire logic signed [ACC_W-1:0]            i_acc,
    input  wire logic signed [cws_pkg::COEF_W-1:0]  i_coef,
    output cws_pkg::t_beat                          o_beat,
    input  wire logic                               i_rdy,
    output logic signed [SAMPLE_BITS:0]             o_x,
    output logic signed [SAMPLE_BITS:0]             o_cur,
    output logic signed [SAMPLE_BITS:0]             o_prev,
    output logic signed [ACC_W-1:0]                 o_acc
);
    import cws_pkg::*;

    localparam int F   = SAMPLE_BITS - 1;
    localparam int XW  = SAMPLE_BITS + 1;
    localparam int PW  = 2 * XW;
    localparam int WPW = COEF_W + XW;
    localparam int HW  = PW - F + 1;
    localparam int DW  = HW + 1;

    localparam logic signed [XW-1:0] ONE     = {2'b01, {F{1'b0}}};
    localparam logic signed [XW-1:0] NEG_ONE = {2'b11, {F{1'b0}}};

    t_beat                   r_a_beat;
    logic signed [XW-1:0]    r_a_x;
    logic signed [XW-1:0]    r_a_cur;
    logic signed [XW-1:0]    r_a_prev;
    logic signed [PW-1:0]    r_a_prod;
    logic signed [WPW-1:0]   r_a_wp;
    logic signed [ACC_W-1:0] r_a_acc;

    t_beat                   r_b_beat;
    logic signed [XW-1:0]    r_b_x;
    logic signed [XW-1:0]    r_b_cur;
    logic signed [XW-1:0]    r_b_prev;
    logic signed [ACC_W-1:0] r_b_acc;

    logic                    n_rdy_a;
    logic                    n_rdy_b;
    logic signed [PW-1:0]    n_prod;
    logic signed [WPW-1:0]   n_wp;
    logic signed [HW-1:0]    n_half;
    logic signed [DW-1:0]    n_diff;
    logic signed [XW-1:0]    n_nxt;
    logic signed [ACC_W-1:0] n_acc;

    assign n_rdy_b = !r_b_beat.vld || i_rdy;
    assign n_rdy_a = !r_a_beat.vld || n_rdy_b;

    assign n_prod = i_x * i_cur;
    assign n_wp   = i_coef * i_cur;

    // floor(2*x*T / 2^F) is x*T shifted right by F-1.
    assign n_half = $signed(r_a_prod[PW-1:F-1]);
    assign n_diff = DW'(n_half) - DW'(r_a_prev);
    assign n_nxt  = (n_diff > DW'(ONE)) ? ONE :
                    ((n_diff < DW'(NEG_ONE)) ? NEG_ONE : n_diff[XW-1:0]);

    assign n_acc = r_a_acc + {{(ACC_W-WPW){r_a_wp[WPW-1]}}, r_a_wp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_beat <= '0;
            r_b_beat <= '0;
        end else begin
            if (n_rdy_a) r_a_beat <= i_beat;
            if (n_rdy_b) r_b_beat <= r_a_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy_a && i_beat.vld) begin
            r_a_x    <= i_x;
            r_a_cur  <= i_cur;
            r_a_prev <= i_prev;
            r_a_prod <= n_prod;
            r_a_wp   <= n_wp;
            r_a_acc  <= i_acc;
        end
        if (n_rdy_b && r_a_beat.vld) begin
            r_b_x    <= r_a_x;
            r_b_cur  <= n_nxt;
            r_b_prev <= r_a_cur;
            r_b_acc  <= n_acc;
        end
    end

    assign o_rdy  = n_rdy_a;
    assign o_beat = r_b_beat;
    assign o_x    = r_b_x;
    assign o_cur  = r_b_cur;
    assign o_prev = r_b_prev;
    assign o_acc  = r_b_acc;

endmodule

`default_nettype wire

// ----- hw/rtl/cws_back.sv -----
`default_nettype none

module cws_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 37
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cws_pkg::t_beat              i_beat,
    output logic                             o_rdy,
    input  wire logic signed [ACC_W-1:0]     i_acc,
    output cws_pkg::t_beat                   o_beat,
    input  wire logic                        i_rdy,
    output logic [cws_pkg::OUT_W-1:0]        o_data
);
    import cws_pkg::*;

    // Sum is Q.(F+12); the result is Q.15.
    localparam int SH = SAMPLE_BITS - 1 + COEF_FRAC - OUT_FRAC;
    localparam int SW = ACC_W - SH;
    localparam int CW = (SW > OUT_W) ? SW : OUT_W;

    localparam logic signed [CW-1:0] OMAX = CW'(OUT_MAX);
    localparam logic signed [CW-1:0] OMIN = CW'(OUT_MIN);

    t_beat               r_o_beat;
    logic [OUT_W-1:0]    r_o_data;

    logic                n_rdy;
    logic signed [SW-1:0] n_sh;
    logic signed [CW-1:0] n_ext;
    logic signed [CW-1:0] n_sat;

    assign n_rdy = !r_o_beat.vld || i_rdy;
    assign n_sh  = $signed(i_acc[ACC_W-1:SH]);
    assign n_ext = CW'(n_sh);
    assign n_sat = (n_ext > OMAX) ? OMAX : ((n_ext < OMIN) ? OMIN : n_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_beat <= '0;
        end else if (n_rdy) begin
            r_o_beat <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy && i_beat.vld) begin
            r_o_data <= n_sat[OUT_W-1:0];
        end
    end

    assign o_rdy  = n_rdy;
    assign o_beat = r_o_beat;
    assign o_data = r_o_data;

endmodule

`default_nettype wire

// ----- hw/rtl/chebyshev_waveshaper_unit.sv -----
// Chebyshev waveshaper: each sample is scaled by the gain, clipped to [-1, 1]
// and mapped through a weighted sum of the first term_count Chebyshev
// polynomials, giving a saturated Q9.15 result.
// Input stream: tdata carries the Q1.15 sample, tlast the end-of-table mark.
// Output stream: tdata carries the 24 bit result, tlast the copied mark.
// Configuration: one write channel (index, data), always ready; write it
// only while no sample is in flight.
// Samples pass through the gain multiply and clip stages, the stages of
// each recurrence cell and the output register. Throughput is one sample
// per cycle while the receiver takes results; every stage is registered
// with its own valid bit.
// Reset empties the pipeline and loads the identity setting (gain near one,
// two terms, weight one on T1). When the receiver stalls, the result holds
// on the output and stages behind it keep filling until each holds a
// sample; tready then drops and nothing is lost or repeated.
`default_nettype none

module chebyshev_waveshaper_unit #(
    parameter int MAX_TERMS   = 6,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // tdata: sample_in [SAMPLE_BITS-1:0], zero fill above
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       i_s_axis_tdata,
    input  wire logic                                   i_s_axis_tvalid,
    // tlast: end_of_table
    input  wire logic                                   i_s_axis_tlast,
    output logic                                        o_s_axis_tready,
    // tdata: shaped_out [23:0]
    output logic [cws_pkg::OUT_W-1:0]                   o_m_axis_tdata,
    output logic                                        o_m_axis_tvalid,
    // tlast: end_flag
    output logic                                        o_m_axis_tlast,
    input  wire logic                                   i_m_axis_tready,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [cws_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [cws_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import cws_pkg::*;

    localparam int F        = SAMPLE_BITS - 1;
    localparam int XW       = SAMPLE_BITS + 1;
    localparam int CNT_W    = $clog2(MAX_TERMS + 1);
    localparam int ACC_W    = COEF_W + XW + CNT_W;
    localparam int NUM_COEF = (MAX_TERMS < COEF_REGS) ? MAX_TERMS : COEF_REGS;

    localparam logic signed [XW-1:0] ONE = {2'b01, {F{1'b0}}};

    logic signed [GAIN_W-1:0] r_gain;
    logic [TC_W-1:0]          r_terms;
    logic signed [COEF_W-1:0] r_coeff [NUM_COEF];

    logic [CFG_IDX_W-1:0]     n_k;
    logic [CNT_W-1:0]         n_terms;

    logic signed [COEF_W-1:0] w_coef [MAX_TERMS];
    t_beat                    w_beat [MAX_TERMS];
    logic                     w_rdy  [MAX_TERMS];
    logic signed [XW-1:0]     w_x    [MAX_TERMS];
    logic signed [XW-1:0]     w_cur  [MAX_TERMS];
    logic signed [XW-1:0]     w_prev [MAX_TERMS];
    logic signed [ACC_W-1:0]  w_acc  [MAX_TERMS];

    t_beat                    w_in_beat;
    t_beat                    w_out_beat;

    assign n_k = i_cfg_index - REG_COEFF0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_terms <= TC_RST;
            for (int e = 0; e < NUM_COEF; e++) begin
                r_coeff[e] <= (e == 1) ? COEF1_RST : '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                REG_GAIN: begin
                    r_gain <= i_cfg_data;
                end
                REG_TERMS: begin
                    r_terms <= i_cfg_data[TC_W-1:0];
                end
                [REG_COEFF0:REG_COEFF5]: begin
                    for (int e = 0; e < NUM_COEF; e++) begin
                        if (n_k == CFG_IDX_W'(e)) r_coeff[e] <= i_cfg_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign n_terms = (r_terms > MAX_TERMS) ? CNT_W'(MAX_TERMS) : CNT_W'(r_terms);

    // Weights of terms beyond the term count, or without a register, are zero.
    for (genvar j = 0; j < MAX_TERMS; j++) begin : g_coef
        if (j < NUM_COEF) begin : g_reg
            assign w_coef[j] = (n_terms > CNT_W'(j)) ? r_coeff[j] : '0;
        end else begin : g_zero
            assign w_coef[j] = '0;
        end
    end

    assign w_in_beat.vld  = i_s_axis_tvalid;
    assign w_in_beat.last = i_s_axis_tlast;

    cws_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_in_beat),
        .o_rdy    (o_s_axis_tready),
        .i_sample (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_gain   (r_gain),
        .i_coef0  (w_coef[0]),
        .o_beat   (w_beat[0]),
        .i_rdy    (w_rdy[0]),
        .o_x      (w_x[0]),
        .o_acc    (w_acc[0])
    );

    // T1 is x itself, and the recurrence for T2 needs T0 as the constant one.
    assign w_cur[0]  = w_x[0];
    assign w_prev[0] = ONE;

    // Cell j adds the weight of T(j) and forms T(j+1).
    for (genvar j = 1; j < MAX_TERMS; j++) begin : g_cell
        cws_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .ACC_W       (ACC_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat[j-1]),
            .o_rdy   (w_rdy[j-1]),
            .i_x     (w_x[j-1]),
            .i_cur   (w_cur[j-1]),
            .i_prev  (w_prev[j-1]),
            .i_acc   (w_acc[j-1]),
            .i_coef  (w_coef[j]),
            .o_beat  (w_beat[j]),
            .i_rdy   (w_rdy[j]),
            .o_x     (w_x[j]),
            .o_cur   (w_cur[j]),
            .o_prev  (w_prev[j]),
            .o_acc   (w_acc[j])
        );
    end

    cws_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat[MAX_TERMS-1]),
        .o_rdy   (w_rdy[MAX_TERMS-1]),
        .i_acc   (w_acc[MAX_TERMS-1]),
        .o_beat  (w_out_beat),
        .i_rdy   (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

    assign o_m_axis_tvalid = w_out_beat.vld;
    assign o_m_axis_tlast  = w_out_beat.last;

endmodule

`default_nettype wire

// ----- hw/rtl/cws_checker.sv -----
`default_nettype none

module cws_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_s_axis_tready,
    input wire logic                        o_m_axis_tvalid,
    input wire logic                        o_m_axis_tlast,
    input wire logic [cws_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input wire logic                        i_m_axis_tready
);

    // Reset empties the pipeline, so no result is offered after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds until its transfer.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // With the output register empty every stage can move, so input is taken.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while the output is empty");

    // An output transfer frees a slot that reaches the input in the same cycle.
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled during an output transfer");

endmodule

bind chebyshev_waveshaper_unit cws_checker u_cws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tready (i_m_axis_tready)
);

`default_nettype wire

// ----- tb/chebyshev_waveshaper_unit_test.sv -----
`default_nettype none

module chebyshev_waveshaper_unit_test;
    import cws_pkg::*;

    localparam int MAX_TERMS   = 6;
    localparam int SAMPLE_BITS = 16;
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC        = SAMPLE_BITS - 1;
    localparam longint UNITY   = longint'(1) <<< FRAC;
    localparam int PIPE_DEPTH  = 2 * MAX_TERMS + 1;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1900;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef enum logic [1:0] {
        FEED_SAMPLE,
        FEED_CFG,
        FEED_HOLD
    } t_feed_op;

    typedef struct {
        t_feed_op                op;
        logic [TDATA_W-1:0]      sample;
        logic                    eot;
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   value;
        int                      gap;
    } t_feed;

    typedef struct {
        logic [OUT_W-1:0] shaped;
        logic             flag;
    } t_shaped;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic [TDATA_W-1:0]    s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tlast = 1'b0;
    wire logic             s_tready;
    wire logic [OUT_W-1:0] m_tdata;
    wire logic             m_tvalid;
    wire logic             m_tlast;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    wire logic             cfg_ready;
    t_cfg_idx              cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the block's registers, updated at each register transfer.
    logic signed [GAIN_W-1:0] cur_gain;
    logic [TC_W-1:0]          cur_terms;
    logic signed [COEF_W-1:0] cur_coeff [MAX_TERMS];

    t_feed   feed_q[$];
    t_shaped shaped_q[$];

    int gap_left = 0;
    int run_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int n_errors = 0;
    int n_samples = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_settings = 0;
    int n_planned = 0;
    logic [7:0] terms_seen = '0;

    chebyshev_waveshaper_unit #(
        .MAX_TERMS   (MAX_TERMS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),   // sample_in
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tlast  (s_tlast),   // end_of_table
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),   // shaped_out
        .o_m_axis_tvalid (m_tvalid),
        .o_m_axis_tlast  (m_tlast),   // end_flag
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic longint clip_unity(longint v);
        if (v > UNITY) begin
            return UNITY;
        end else if (v < -UNITY) begin
            return -UNITY;
        end
        return v;
    endfunction

    function automatic t_shaped shape_sample(logic signed [SAMPLE_BITS-1:0] smp, logic eot);
        t_shaped res;
        longint  x;
        longint  t;
        longint  t_prev;
        longint  t_prev2;
        longint  acc;
        int      n;
        x = clip_unity((longint'(smp) * longint'(cur_gain)) >>> GAIN_SHIFT);
        n = (cur_terms > MAX_TERMS) ? MAX_TERMS : int'(cur_terms);
        t = UNITY;
        t_prev = x;
        t_prev2 = UNITY;
        acc = 0;
        for (int k = 0; k < n; k++) begin
            if (k == 0) begin
                t = UNITY;
            end else if (k == 1) begin
                t = x;
            end else begin
                t = clip_unity(((2 * x * t_prev) >>> FRAC) - t_prev2);
                t_prev2 = t_prev;
                t_prev = t;
            end
            acc += longint'(cur_coeff[k]) * t;
        end
        // Products are Q.(FRAC+12); the result keeps 15 fraction bits.
        acc = acc >>> (FRAC + COEF_FRAC - OUT_FRAC);
        if (acc > OUT_MAX) begin
            acc = OUT_MAX;
        end else if (acc < OUT_MIN) begin
            acc = OUT_MIN;
        end
        res.shaped = acc[OUT_W-1:0];
        res.flag = eot;
        return res;
    endfunction

    function automatic void store_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        int k;
        if (idx == REG_GAIN) begin
            cur_gain = value;
        end else if (idx == REG_TERMS) begin
            cur_terms = value[TC_W-1:0];
            terms_seen[value[TC_W-1:0]] = 1'b1;
        end else if (idx >= REG_COEFF0 && idx <= REG_COEFF5) begin
            k = int'(idx) - int'(REG_COEFF0);
            if (k < MAX_TERMS) begin
                cur_coeff[k] = value;
            end
        end
    endfunction

    function automatic logic [15:0] corner_word();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return corner_word();
        end else if (r == 1) begin
            return 16'($urandom_range(0, 255)) ^ {16{1'($urandom)}};
        end
        return 16'($urandom);
    endfunction

    task automatic add_sample(logic [15:0] v, logic eot, int gap);
        t_feed f;
        f.op = FEED_SAMPLE;
        f.sample = v;
        f.eot = eot;
        f.idx = '0;
        f.value = '0;
        f.gap = gap;
        feed_q.push_back(f);
        n_planned++;
    endtask

    task automatic add_write(t_cfg_idx idx, logic [15:0] value);
        t_feed f;
        f.op = FEED_CFG;
        f.sample = '0;
        f.eot = 1'b0;
        f.idx = idx;
        f.value = value;
        f.gap = 0;
        feed_q.push_back(f);
    endtask

    task automatic add_hold();
        t_feed f;
        f.op = FEED_HOLD;
        f.sample = '0;
        f.eot = 1'b0;
        f.idx = '0;
        f.value = '0;
        f.gap = 0;
        feed_q.push_back(f);
    endtask

    task automatic add_setting(logic [15:0] gain, logic [2:0] terms, logic [15:0] c0,
                               logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
                               logic [15:0] c4, logic [15:0] c5);
        add_write(REG_GAIN, gain);
        add_write(REG_TERMS, 16'(terms));
        add_write(t_cfg_idx'(int'(REG_COEFF0) + 0), c0);
        add_write(t_cfg_idx'(int'(REG_COEFF0) + 1), c1);
        add_write(t_cfg_idx'(int'(REG_COEFF0) + 2), c2);
        add_write(t_cfg_idx'(int'(REG_COEFF0) + 3), c3);
        add_write(t_cfg_idx'(int'(REG_COEFF0) + 4), c4);
        add_write(REG_COEFF5, c5);
        n_settings++;
    endtask

    task automatic add_random_setting();
        logic [15:0] w;
        add_write(REG_GAIN, ($urandom_range(0, 4) == 0) ? corner_word() : 16'($urandom));
        add_write(REG_TERMS, 16'($urandom_range(0, 7)));
        for (int k = 0; k < COEF_REGS; k++) begin
            w = ($urandom_range(0, 6) == 0) ? corner_word() : 16'($urandom);
            if ($urandom_range(0, 4) != 0) begin
                add_write(t_cfg_idx'(int'(REG_COEFF0) + k), w);
            end
        end
        n_settings++;
    endtask

    // Sample side. Expectations are formed at the input transfer, with the
    // registers as they stand then.
    always @(posedge i_clk) begin : drive
        t_feed head;
        logic  nxt_valid;
        logic  nxt_cfg;
        if (i_rst_n) begin
            nxt_valid = s_tvalid;
            nxt_cfg = cfg_valid;
            if (s_tvalid && s_tready) begin
                shaped_q.push_back(shape_sample(s_tdata, s_tlast));
                n_samples++;
                nxt_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                store_reg(cfg_index, cfg_data);
                n_writes++;
                nxt_cfg = 1'b0;
            end
            if (!nxt_valid && !nxt_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (feed_q.size() > 0) begin
                    head = feed_q[0];
                    case (head.op)
                        FEED_SAMPLE: begin
                            s_tdata <= head.sample;
                            s_tlast <= head.eot;
                            nxt_valid = 1'b1;
                            gap_left = head.gap;
                            void'(feed_q.pop_front());
                        end
                        FEED_CFG: begin
                            // Registers change only with the pipeline empty.
                            if (shaped_q.size() == 0) begin
                                cfg_index <= head.idx;
                                cfg_data <= head.value;
                                nxt_cfg = 1'b1;
                                void'(feed_q.pop_front());
                            end
                        end
                        FEED_HOLD: begin
                            if (shaped_q.size() == 0) begin
                                void'(feed_q.pop_front());
                            end
                        end
                        default: begin
                            void'(feed_q.pop_front());
                        end
                    endcase
                end
            end
            s_tvalid <= nxt_valid;
            cfg_valid <= nxt_cfg;
        end
    end

    // Result side: check each output transfer and throttle tready.
    always @(posedge i_clk) begin : watch
        t_shaped want;
        logic    nxt_ready;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (shaped_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual shaped %h flag %b",
                             $time, m_tdata, m_tlast);
                    n_errors++;
                end else begin
                    want = shaped_q.pop_front();
                    n_results++;
                    if (m_tdata !== want.shaped) begin
                        $display("%0t: shaped_out mismatch: expected %h, actual %h",
                                 $time, want.shaped, m_tdata);
                        n_errors++;
                    end
                    if (m_tlast !== want.flag) begin
                        $display("%0t: end_flag mismatch: expected %b, actual %b",
                                 $time, want.flag, m_tlast);
                        n_errors++;
                    end
                end
            end
            if (run_left > 0) begin
                nxt_ready = 1'b1;
                run_left--;
            end else if (stall_left > 0) begin
                nxt_ready = 1'b0;
                stall_left--;
            end else begin
                nxt_ready = 1'b1;
                run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 20)
                                                         : $urandom_range(100, 400);
                stall_left = pick_gap();
            end
            m_tready <= nxt_ready;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int phase_len;
        int gap_mode;
        cur_gain = GAIN_RST;
        cur_terms = TC_RST;
        for (int k = 0; k < MAX_TERMS; k++) begin
            cur_coeff[k] = '0;
        end
        cur_coeff[1] = COEF1_RST;
        terms_seen[TC_RST] = 1'b1;

        // Identity setting straight out of reset.
        add_sample(16'h8000, 1'b1, 0);
        add_sample(16'h7fff, 1'b0, 0);
        add_sample(16'h0000, 1'b0, 2);
        add_sample(16'h0001, 1'b0, 0);
        add_sample(16'hffff, 1'b1, 0);
        add_sample(16'h4000, 1'b0, 5);
        add_sample(16'hc000, 1'b1, 0);
        // Most negative gain makes x reach exactly +1.0; all weights at the top.
        add_setting(16'h8000, 3'd6, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'h7fff);
        add_sample(16'h8000, 1'b0, 0);
        add_sample(16'h7fff, 1'b1, 0);
        add_sample(16'h0000, 1'b0, 0);
        add_sample(16'h1234, 1'b0, 0);
        add_hold();
        // A term count above the number of terms is treated as the maximum.
        add_setting(16'h7fff, 3'd7, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h8000);
        add_sample(16'h8000, 1'b1, 0);
        add_sample(16'h7fff, 1'b0, 1);
        add_sample(16'hc000, 1'b0, 0);
        add_write(REG_TERMS, 16'd0);
        add_sample(16'h7fff, 1'b0, 0);
        add_sample(16'h8000, 1'b1, 0);
        // Zero gain leaves only the constant term.
        add_setting(16'h0000, 3'd1, 16'h1000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000);
        add_sample(16'h7fff, 1'b0, 0);
        add_sample(16'h8000, 1'b0, 0);
        add_setting(16'h4000, 3'd3, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000,
                    16'h0000);
        add_sample(16'h8000, 1'b0, 0);
        add_sample(16'h7fff, 1'b1, 0);
        add_sample(16'h0001, 1'b0, 0);

        n_planned = 0;
        while (n_planned < RANDOM_ITEMS) begin
            add_random_setting();
            phase_len = $urandom_range(40, 250);
            gap_mode = $urandom_range(0, 2);
            for (int i = 0; i < phase_len && n_planned < RANDOM_ITEMS; i++) begin
                add_sample(pick_sample(), ($urandom_range(0, 7) == 0),
                           (gap_mode == 0) ? 0 : pick_gap());
                if ($urandom_range(0, 149) == 0) begin
                    add_hold();
                end
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || s_tvalid || cfg_valid || shaped_q.size() != 0) begin
            @(posedge i_clk);
        end
        // The last item taken from the queue shows its tvalid after the next edge.
        repeat (2) @(posedge i_clk);
        while (feed_q.size() != 0 || s_tvalid || cfg_valid || shaped_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 16) @(posedge i_clk);

        $display("Sent %0d samples and checked %0d results over %0d register settings.",
                 n_samples, n_results, n_settings);
        $display("Register writes: %0d; term counts seen (bit per count): %b.",
                 n_writes, terms_seen);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
